>>> hw/rtl/line_pixel_stepper_defines.svh
// Assertion macros used by the port-level checker of the line pixel stepper.
// Depends on nothing; files that assert take it by include.
`ifndef LINE_PIXEL_STEPPER_DEFINES_SVH
`define LINE_PIXEL_STEPPER_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored during reset.
`define LPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and ignored during reset.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lps_pkg.sv
// Shared types and constants of the line pixel stepper.
// Used by the walk core, the top level and the checker; depends on nothing.
package lps_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 32;
  localparam int DEC_BITS   = COORD_BITS + 3;
  localparam int INC_BITS   = COORD_BITS + 2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                  command;
    coord_t                start_x;
    coord_t                start_y;
    coord_t                end_x;
    coord_t                end_y;
    logic [COLOR_BITS-1:0] color;
  } in_item_t;

  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    coord_t                run_length;
    logic [COLOR_BITS-1:0] color_out;
    logic                  last;
    logic                  valid_res;
  } out_item_t;

  typedef struct packed {
    coord_t                      cur_x;
    coord_t                      cur_y;
    coord_t                      target_x;
    coord_t                      target_y;
    logic signed [DEC_BITS-1:0]  decision;
    logic [INC_BITS-1:0]         incr_straight;
    logic signed [DEC_BITS-1:0]  incr_diagonal;
    logic                        step_neg_x;
    logic                        step_neg_y;
    logic                        x_major;
    logic                        active;
    logic [COLOR_BITS-1:0]       line_color;
  } walk_state_t;

endpackage

>>> hw/rtl/lps_core.sv
// Walk state and one step of the midpoint line walk per fired command.
// Depends on lps_pkg.
module lps_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  lps_pkg::in_item_t  item,
  output lps_pkg::out_item_t result
);
  import lps_pkg::*;

  walk_state_t st;
  walk_state_t st_next;

  logic                       neg_x;
  logic                       neg_y;
  coord_t                     dx;
  coord_t                     dy;
  logic                       xmaj;
  coord_t                     major;
  coord_t                     minor;
  logic signed [DEC_BITS-1:0] start_dec;
  logic signed [DEC_BITS-1:0] start_diag;
  logic                       diag;
  logic signed [DEC_BITS-1:0] dec_step;
  coord_t                     nx;
  coord_t                     ny;
  logic                       done;

  function automatic coord_t step_coord(input coord_t v, input logic neg);
    coord_t r;
    r = neg ? (v - COORD_BITS'(1)) : (v + COORD_BITS'(1));
    return r;
  endfunction

  // Setup arithmetic for a start command.
  assign neg_x      = item.start_x > item.end_x;
  assign neg_y      = item.start_y > item.end_y;
  assign dx         = neg_x ? (item.start_x - item.end_x) : (item.end_x - item.start_x);
  assign dy         = neg_y ? (item.start_y - item.end_y) : (item.end_y - item.start_y);
  assign xmaj       = dx > dy;
  assign major      = xmaj ? dx : dy;
  assign minor      = xmaj ? dy : dx;
  assign start_dec  = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
  assign start_diag = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});

  // One walk step from the stored state.
  assign diag     = !st.decision[DEC_BITS-1] && (st.decision != '0);
  assign dec_step = st.decision +
                    (diag ? st.incr_diagonal : $signed({1'b0, st.incr_straight}));

  always_comb begin
    st_next = st;
    result  = '0;
    nx      = st.cur_x;
    ny      = st.cur_y;
    done    = 1'b0;
    if (item.command == CMD_START) begin
      st_next.line_color = item.color;
      st_next.cur_x      = item.start_x;
      st_next.cur_y      = item.start_y;
      st_next.target_x   = item.end_x;
      st_next.target_y   = item.end_y;
      st_next.step_neg_x = neg_x;
      st_next.step_neg_y = neg_y;
      result.color_out   = item.color;
      result.valid_res   = 1'b1;
      if (item.start_y == item.end_y) begin
        // A horizontal line goes out at once as one run from its left end.
        st_next.active    = 1'b0;
        result.pixel_x    = neg_x ? item.end_x : item.start_x;
        result.pixel_y    = item.start_y;
        result.run_length = dx;
        result.last       = 1'b1;
      end else begin
        st_next.x_major       = xmaj;
        st_next.decision      = start_dec;
        st_next.incr_straight = {1'b0, minor, 1'b0};
        st_next.incr_diagonal = start_diag;
        st_next.active        = 1'b1;
        result.pixel_x        = item.start_x;
        result.pixel_y        = item.start_y;
        result.run_length     = COORD_BITS'(1);
      end
    end else if (st.active) begin
      st_next.decision = dec_step;
      if (st.x_major) begin
        nx   = step_coord(st.cur_x, st.step_neg_x);
        ny   = diag ? step_coord(st.cur_y, st.step_neg_y) : st.cur_y;
        done = nx == st.target_x;
      end else begin
        ny   = step_coord(st.cur_y, st.step_neg_y);
        nx   = diag ? step_coord(st.cur_x, st.step_neg_x) : st.cur_x;
        done = ny == st.target_y;
      end
      st_next.cur_x     = nx;
      st_next.cur_y     = ny;
      st_next.active    = !done;
      result.pixel_x    = nx;
      result.pixel_y    = ny;
      result.run_length = COORD_BITS'(1);
      result.color_out  = st.line_color;
      result.last       = done;
      result.valid_res  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

>>> hw/rtl/line_pixel_stepper.sv
// Top level of the line pixel stepper: command register, walk core, result register.
// Depends on lps_pkg and lps_core.
//
//   channel  direction  payload      handshake
//   cmd      in         in_item_t    cmd_valid / cmd_stall
//   pix      out        out_item_t   pix_valid / pix_stall
//
// Each command yields one result via the command register, then the result register.
// One command is taken every cycle while cmd_stall is low; the walk core steps once
// per cycle in which a command advances. A stalled result holds in the output register
// while one more command waits in the input register; only then is cmd_stall raised.
// Reset (rst, synchronous) empties both registers and ends any active line.
module line_pixel_stepper (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  lps_pkg::in_item_t  cmd,
  output logic               pix_valid,
  input  logic               pix_stall,
  output lps_pkg::out_item_t pix
);
  import lps_pkg::*;

  logic      in_full;
  in_item_t  in_q;
  logic      out_full;
  out_item_t out_q;
  out_item_t result;
  logic      out_free;
  logic      adv;

  assign out_free  = !out_full || !pix_stall;
  assign adv       = in_full && out_free;
  assign cmd_stall = in_full && !out_free;
  assign pix_valid = out_full;
  assign pix       = out_q;

  lps_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (adv),
    .item   (in_q),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (!cmd_stall) begin
        in_full <= cmd_valid;
      end
      if (out_free) begin
        out_full <= in_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_q <= cmd;
    end
    if (adv) begin
      out_q <= result;
    end
  end

endmodule

>>> hw/rtl/lps_checker.sv
// Port-level assertions for the line pixel stepper, bound to its top level.
// Depends on lps_pkg and line_pixel_stepper_defines.svh.
`include "line_pixel_stepper_defines.svh"

module lps_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input lps_pkg::in_item_t  cmd,
  input logic               pix_valid,
  input logic               pix_stall,
  input lps_pkg::out_item_t pix
);
  import lps_pkg::*;

  // A result that is stalled stays as it is for the next transfer.
  `LPS_ASSERT_NEXT(a_pix_hold, pix_valid && pix_stall, pix_valid && $stable(pix), "stalled result changed")

  // A step with no active line carries nothing but zeros.
  `LPS_ASSERT_NOW(a_idle_zero, pix_valid && !pix.valid_res, pix.pixel_x == '0 && pix.pixel_y == '0 && pix.run_length == '0 && pix.color_out == '0 && !pix.last, "idle step has nonzero fields")

  // Only a horizontal run has a length other than one, and it always ends its line.
  `LPS_ASSERT_NOW(a_run_last, pix_valid && pix.valid_res && pix.run_length != COORD_BITS'(1), pix.last, "run without last")

  // The input side never stalls while the output register is free.
  `LPS_ASSERT_NOW(a_no_false_stall, cmd_stall, pix_valid && pix_stall, "command stalled with free output")

endmodule

bind line_pixel_stepper lps_checker u_lps_checker (.*);

>>> tb/lps_pixel_checker.sv
// Checker for the line pixel stepper: predicts each result from the command transfers
// and compares the pixel transfers against it in order. Depends on lps_pkg only.
module lps_pixel_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  lps_pkg::in_item_t  cmd,
  input  logic               pix_valid,
  input  logic               pix_stall,
  input  lps_pkg::out_item_t pix,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lps_pkg::*;

  // Walk state of the predicted rasterizer.
  coord_t            pos_x, pos_y, goal_x, goal_y;
  int                err_acc, err_step_straight, err_step_diag;
  logic              down_x, down_y, walk_x, walking;
  logic [COLOR_BITS-1:0] held_color;

  out_item_t expected_pixels[$];
  int        mismatches = 0;

  task automatic clear_walk();
    pos_x = '0;
    pos_y = '0;
    goal_x = '0;
    goal_y = '0;
    err_acc = 0;
    err_step_straight = 0;
    err_step_diag = 0;
    down_x = 1'b0;
    down_y = 1'b0;
    walk_x = 1'b0;
    walking = 1'b0;
    held_color = '0;
  endtask

  task automatic rasterize_cmd(input in_item_t c, output out_item_t r);
    int     dx, dy;
    coord_t lo, hi;
    logic   diag, done;
    r = '0;
    if (c.command == CMD_START) begin
      held_color = c.color;
      pos_x  = c.start_x;
      pos_y  = c.start_y;
      goal_x = c.end_x;
      goal_y = c.end_y;
      down_x = c.start_x > c.end_x;
      down_y = c.start_y > c.end_y;
      if (c.start_y == c.end_y) begin
        // A horizontal line goes out as one run and leaves no walk behind.
        lo = down_x ? c.end_x : c.start_x;
        hi = down_x ? c.start_x : c.end_x;
        walking = 1'b0;
        r.pixel_x    = lo;
        r.pixel_y    = c.start_y;
        r.run_length = hi - lo;
        r.color_out  = held_color;
        r.last       = 1'b1;
        r.valid_res  = 1'b1;
      end else begin
        dx = down_x ? int'(c.start_x) - int'(c.end_x) : int'(c.end_x) - int'(c.start_x);
        dy = down_y ? int'(c.start_y) - int'(c.end_y) : int'(c.end_y) - int'(c.start_y);
        walk_x = dx > dy;
        if (walk_x) begin
          err_acc           = 2 * dy - dx;
          err_step_straight = 2 * dy;
          err_step_diag     = 2 * (dy - dx);
        end else begin
          err_acc           = 2 * dx - dy;
          err_step_straight = 2 * dx;
          err_step_diag     = 2 * (dx - dy);
        end
        walking = 1'b1;
        r.pixel_x    = c.start_x;
        r.pixel_y    = c.start_y;
        r.run_length = coord_t'(1);
        r.color_out  = held_color;
        r.last       = 1'b0;
        r.valid_res  = 1'b1;
      end
    end else if (walking) begin
      diag = err_acc > 0;
      err_acc += diag ? err_step_diag : err_step_straight;
      if (walk_x) begin
        pos_x = down_x ? pos_x - 1'b1 : pos_x + 1'b1;
        if (diag) pos_y = down_y ? pos_y - 1'b1 : pos_y + 1'b1;
        done = pos_x == goal_x;
      end else begin
        pos_y = down_y ? pos_y - 1'b1 : pos_y + 1'b1;
        if (diag) pos_x = down_x ? pos_x - 1'b1 : pos_x + 1'b1;
        done = pos_y == goal_y;
      end
      if (done) walking = 1'b0;
      r.pixel_x    = pos_x;
      r.pixel_y    = pos_y;
      r.run_length = coord_t'(1);
      r.color_out  = held_color;
      r.last       = done;
      r.valid_res  = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want, got;
    if (rst) begin
      clear_walk();
      expected_pixels.delete();
    end else begin
      // Results are taken before commands: a result never belongs to a command
      // that transfers at the same edge.
      if (pix_valid && !pix_stall) begin
        got = pix;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel transfer: x=%0d y=%0d len=%0d color=%h last=%b valid=%b",
                     got.pixel_x, got.pixel_y, got.run_length, got.color_out, got.last,
                     got.valid_res);
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
              got.run_length !== want.run_length || got.color_out !== want.color_out ||
              got.last !== want.last || got.valid_res !== want.valid_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("pixel mismatch at %0t", $realtime);
              $display("  expected x=%0d y=%0d len=%0d color=%h last=%b valid=%b",
                       want.pixel_x, want.pixel_y, want.run_length, want.color_out,
                       want.last, want.valid_res);
              $display("  actual   x=%0d y=%0d len=%0d color=%h last=%b valid=%b",
                       got.pixel_x, got.pixel_y, got.run_length, got.color_out,
                       got.last, got.valid_res);
            end
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        rasterize_cmd(cmd, want);
        expected_pixels.push_back(want);
      end
    end
    errors  <= mismatches;
    pending <= expected_pixels.size();
  end

endmodule

>>> tb/tb_line_pixel_stepper.sv
// Testbench top for the line pixel stepper: clock, reset, command stimulus and
// a randomly stalling result receiver. Depends on lps_pkg, line_pixel_stepper, lps_pixel_checker.
module tb_line_pixel_stepper;
  timeunit 1ns;
  timeprecision 1ps;
  import lps_pkg::*;

  logic      clk;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  in_item_t  cmd_item = '0;
  logic      pix_stall = 1'b0;
  logic      cmd_stall;
  logic      pix_valid;
  out_item_t pix_item;
  int        fail_count;
  int        pending_pixels;
  int        cmds_sent = 0;
  int        burst_left = 0;
  bit        draining = 1'b0;

  line_pixel_stepper u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_item),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix_item)
  );

  lps_pixel_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_item),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix_item),
    .errors    (fail_count),
    .pending   (pending_pixels)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_cmd(input in_item_t item);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 99) < 3) begin
      burst_left = $urandom_range(20, 80);
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_item  <= item;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    cmds_sent++;
  endtask

  task automatic line_cmd(input int x1, input int y1, input int x2, input int y2,
                          input logic [COLOR_BITS-1:0] color);
    in_item_t c;
    c.command = CMD_START;
    c.start_x = coord_t'(x1);
    c.start_y = coord_t'(y1);
    c.end_x   = coord_t'(x2);
    c.end_y   = coord_t'(y2);
    c.color   = color;
    send_cmd(c);
  endtask

  // The endpoint and color fields of a step are ignored, so they carry noise.
  task automatic step_cmd();
    in_item_t c;
    c.command = CMD_NEXT;
    c.start_x = coord_t'($urandom);
    c.start_y = coord_t'($urandom);
    c.end_x   = coord_t'($urandom);
    c.end_y   = coord_t'($urandom);
    c.color   = $urandom;
    send_cmd(c);
  endtask

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  task automatic random_line();
    int x1, y1, x2, y2, spread, dx, dy, len, steps, r;
    bit wide;
    x1 = $urandom_range(0, 4095);
    y1 = $urandom_range(0, 4095);
    wide = $urandom_range(0, 99) < 8;
    if (wide) begin
      x2 = $urandom_range(0, 4095);
      y2 = $urandom_range(0, 4095);
    end else begin
      spread = ($urandom_range(0, 9) == 0) ? 60 : 8;
      x2 = x1 + int'($urandom_range(0, 2 * spread)) - spread;
      y2 = y1 + int'($urandom_range(0, 2 * spread)) - spread;
      r = $urandom_range(0, 19);
      if (r == 0) y2 = y1;
      else if (r == 1) x2 = x1;
      else if (r == 2) y2 = ($urandom_range(0, 1) != 0) ? y1 + (x2 - x1) : y1 - (x2 - x1);
      x2 = clamp_coord(x2);
      y2 = clamp_coord(y2);
    end
    dx = (x2 > x1) ? x2 - x1 : x1 - x2;
    dy = (y2 > y1) ? y2 - y1 : y1 - y2;
    len = (dy == 0) ? 0 : ((dx > dy) ? dx : dy);
    line_cmd(x1, y1, x2, y2, $urandom);
    // Wide lines are cut short by the next start; short ones mostly run to the end.
    r = $urandom_range(0, 99);
    if (wide) steps = $urandom_range(0, 40);
    else if (r < 80) steps = len;
    else if (r < 92) steps = len + $urandom_range(1, 3);
    else steps = (len > 0) ? $urandom_range(0, len - 1) : 1;
    repeat (steps) step_cmd();
  endtask

  // Result receiver: stall runs between stretches of free flow.
  initial begin
    int n;
    forever begin
      if (draining) begin
        pix_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = ($urandom_range(0, 99) < 10) ? $urandom_range(40, 150) : $urandom_range(1, 12);
        pix_stall <= 1'b0;
        repeat (n) @(posedge clk);
        n = pick_gap();
        if (n > 0) begin
          pix_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    step_cmd();                                      // step with no line
    line_cmd(0, 0, 4095, 0, 32'hFFFF_FFFF);          // widest horizontal run
    step_cmd();                                      // horizontal leaves no walk
    line_cmd(4095, 4095, 4095, 4095, 32'h0000_0000); // both endpoints equal
    line_cmd(4095, 7, 0, 7, 32'hA5A5_5A5A);          // horizontal, right to left
    line_cmd(5, 4095, 5, 4092, 32'h1234_5678);       // vertical, upward
    repeat (3) step_cmd();
    step_cmd();                                      // step after the line ended
    line_cmd(4095, 0, 4092, 2, 32'h8000_0001);       // x-major, x falling
    repeat (3) step_cmd();
    line_cmd(0, 4095, 2, 4090, 32'h7FFF_FFFE);       // y-major, y falling
    repeat (2) step_cmd();
    line_cmd(100, 100, 103, 103, 32'hC0DE_F00D);     // diagonal
    step_cmd();
    line_cmd(7, 9, 1, 3, 32'h0F0F_0F0F);             // start while a line is active
    repeat (6) step_cmd();

    // Random part.
    while (cmds_sent < 1950) begin
      if ($urandom_range(0, 99) < 4) step_cmd();
      else random_line();
    end

    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    draining = 1'b1;
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/lps_pkg.sv
hw/rtl/lps_core.sv
hw/rtl/line_pixel_stepper.sv
hw/rtl/lps_checker.sv
tb/lps_pixel_checker.sv
tb/tb_line_pixel_stepper.sv
